/* design/ircp_pkg.sv */
// Shared types, constants and lookup functions for the IR command decoder with clip player.
package ircp_pkg;

  localparam int MaxSlots     = 50;
  localparam int CmdFirstSlot = 17;
  localparam int CmdBits      = 8;

  localparam int SlotW   = 6;
  localparam int TimeW   = 20;
  localparam int PeriodW = 7;
  localparam int PosW    = 13;
  localparam int ClipW   = 2;
  localparam int CfgIdxW = 3;

  localparam logic [TimeW-1:0] TimeMax = '1;

  localparam logic [TimeW-1:0]   RstLeaderMin    = 20'd10000;
  localparam logic [TimeW-1:0]   RstLeaderMax    = 20'd14000;
  localparam logic [TimeW-1:0]   RstOneMin       = 20'd2000;
  localparam logic [TimeW-1:0]   RstOneMax       = 20'd2300;
  localparam logic [TimeW-1:0]   RstFrameTimeout = 20'd1000000;
  localparam logic [PeriodW-1:0] RstSamplePeriod = 7'd125;

  localparam logic [CmdBits-1:0] CodeClip0 = 8'd22;
  localparam logic [CmdBits-1:0] CodeClip1 = 8'd12;
  localparam logic [CmdBits-1:0] CodeClip2 = 8'd24;
  localparam logic [CmdBits-1:0] CodeClip3 = 8'd94;

  localparam logic [PosW-1:0] LenClip0 = 13'd5476;
  localparam logic [PosW-1:0] LenClip1 = 13'd4021;
  localparam logic [PosW-1:0] LenClip2 = 13'd5226;
  localparam logic [PosW-1:0] LenClip3 = 13'd4517;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLeaderMin    = 3'd0,
    CfgLeaderMax    = 3'd1,
    CfgOneMin       = 3'd2,
    CfgOneMax       = 3'd3,
    CfgFrameTimeout = 3'd4,
    CfgSamplePeriod = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [TimeW-1:0]   leader_min;
    logic [TimeW-1:0]   leader_max;
    logic [TimeW-1:0]   one_min;
    logic [TimeW-1:0]   one_max;
    logic [TimeW-1:0]   frame_timeout;
    logic [PeriodW-1:0] sample_period;
  } cfg_t;

  typedef struct packed {
    logic               first_edge;
    logic               done;
    logic               ok;
    logic [CmdBits-1:0] cmd;
    logic               start;
    logic [ClipW-1:0]   clip;
  } dec_evt_t;

  typedef struct packed {
    logic             valid;
    logic [ClipW-1:0] clip;
    logic [PosW-1:0]  index;
  } smp_t;

  typedef struct packed {
    logic             hit;
    logic [ClipW-1:0] clip;
  } clip_hit_t;

  function automatic clip_hit_t clip_lookup(logic [CmdBits-1:0] cmd);
    clip_hit_t r;
    r = '0;
    unique case (cmd)
      CodeClip0: r = '{hit: 1'b1, clip: 2'd0};
      CodeClip1: r = '{hit: 1'b1, clip: 2'd1};
      CodeClip2: r = '{hit: 1'b1, clip: 2'd2};
      CodeClip3: r = '{hit: 1'b1, clip: 2'd3};
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [PosW-1:0] clip_len(logic [ClipW-1:0] clip);
    logic [PosW-1:0] r;
    unique case (clip)
      2'd0:    r = LenClip0;
      2'd1:    r = LenClip1;
      2'd2:    r = LenClip2;
      default: r = LenClip3;
    endcase
    return r;
  endfunction

endpackage

/* design/ircp_decoder.sv */
// Frame timing, slot capture and command decode of the IR receiver edge stream.
module ircp_decoder import ircp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  logic     edge_i,
  input  cfg_t     cfg_i,
  output dec_evt_t evt_o
);

  logic               open_q, open_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [TimeW-1:0]   since_q, since_d;
  logic [TimeW-1:0]   leader_q, leader_d;
  logic [CmdBits-1:0] bits_q, bits_d;

  logic [TimeW-1:0] since_sat;
  logic [TimeW-1:0] timeout;
  logic [SlotW-1:0] slot_diff;
  logic [2:0]       bit_sel;
  logic             one_hit;
  logic             leader_hit;
  clip_hit_t        lookup;

  assign since_sat  = (since_q == TimeMax) ? since_q : since_q + 1'b1;
  assign timeout    = (cfg_i.frame_timeout == '0) ? TimeW'(1) : cfg_i.frame_timeout;
  assign slot_diff  = slot_q - SlotW'(CmdFirstSlot);
  assign bit_sel    = slot_diff[2:0];
  assign one_hit    = (since_sat >= cfg_i.one_min) && (since_sat <= cfg_i.one_max);
  assign leader_hit = (leader_q >= cfg_i.leader_min) && (leader_q <= cfg_i.leader_max);
  assign lookup     = clip_lookup(bits_q);

  always_comb begin
    open_d   = open_q;
    slot_d   = slot_q;
    since_d  = since_q;
    leader_d = leader_q;
    bits_d   = bits_q;
    evt_o    = '0;
    if (edge_i) begin
      if (!open_q) begin
        open_d           = 1'b1;
        slot_d           = '0;
        since_d          = '0;
        evt_o.first_edge = 1'b1;
      end else begin
        if (slot_q < SlotW'(MaxSlots)) begin
          if (slot_q == '0) begin
            leader_d = since_sat;
          end
          if ((slot_q >= SlotW'(CmdFirstSlot)) &&
              (slot_q < SlotW'(CmdFirstSlot + CmdBits))) begin
            bits_d[bit_sel] = one_hit;
          end
          slot_d = slot_q + 1'b1;
        end
        since_d = '0;
      end
    end else if (open_q) begin
      if (since_sat >= timeout) begin
        evt_o.done = 1'b1;
        if (leader_hit) begin
          evt_o.ok    = 1'b1;
          evt_o.cmd   = bits_q;
          evt_o.start = lookup.hit;
          evt_o.clip  = lookup.clip;
        end
        open_d   = 1'b0;
        leader_d = '0;
        slot_d   = '0;
        since_d  = '0;
      end else begin
        since_d = since_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      slot_q   <= '0;
      since_q  <= '0;
      leader_q <= '0;
      bits_q   <= '0;
    end else if (step_i) begin
      open_q   <= open_d;
      slot_q   <= slot_d;
      since_q  <= since_d;
      leader_q <= leader_d;
      bits_q   <= bits_d;
    end
  end

endmodule

/* design/ircp_player.sv */
// Clip playback sequencer: one sample index per sample period until the clip ends or a new frame starts.
module ircp_player import ircp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  dec_evt_t           evt_i,
  input  logic [PeriodW-1:0] period_i,
  output smp_t               smp_o
);

  logic               playing_q, playing_d;
  logic [ClipW-1:0]   clip_q, clip_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [PeriodW-1:0] pc_q, pc_d;

  logic [PeriodW-1:0] period;
  logic [PeriodW-1:0] pc_inc;
  logic [PosW-1:0]    pos_inc;

  assign period  = (period_i == '0) ? PeriodW'(1) : period_i;
  assign pc_inc  = pc_q + 1'b1;
  assign pos_inc = pos_q + 1'b1;

  always_comb begin
    playing_d = playing_q;
    clip_d    = clip_q;
    pos_d     = pos_q;
    pc_d      = pc_q;
    smp_o     = '0;
    priority if (evt_i.first_edge) begin
      playing_d = 1'b0;
    end else if (evt_i.start) begin
      playing_d = 1'b1;
      clip_d    = evt_i.clip;
      pos_d     = '0;
      pc_d      = '0;
    end else if (playing_q) begin
      pc_d = pc_inc;
      if (pc_inc >= period) begin
        pc_d        = '0;
        smp_o.valid = 1'b1;
        smp_o.clip  = clip_q;
        smp_o.index = pos_q;
        pos_d       = pos_inc;
        if (pos_inc >= clip_len(clip_q)) begin
          playing_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q <= 1'b0;
      clip_q    <= '0;
      pos_q     <= '0;
      pc_q      <= '0;
    end else if (step_i) begin
      playing_q <= playing_d;
      clip_q    <= clip_d;
      pos_q     <= pos_d;
      pc_q      <= pc_d;
    end
  end

endmodule

/* design/ir_command_decoder_clip_player_unit.sv */
// Output: a result word is registered onto the outputs when its input word is accepted.
// Throughput: one input word per cycle unless a held result is stalled by out_ready_i;
// the output register lets a new word in while the held result is taken in the same cycle.
// Reset: rst_ni clears frame and playback state and returns all settings to their
// power-on values; no clearing pass is needed.
module ir_command_decoder_clip_player_unit import ircp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               edge_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               sample_valid_o,
  output logic [ClipW-1:0]   clip_o,
  output logic [PosW-1:0]    sample_index_o,
  output logic               frame_done_o,
  output logic               frame_ok_o,
  output logic [CmdBits-1:0] command_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TimeW-1:0]   cfg_data_i
);

  cfg_t     cfg_q;
  dec_evt_t evt;
  smp_t     smp;
  logic     step;
  logic     out_valid_q;

  logic               svalid_q, done_q, ok_q;
  logic [ClipW-1:0]   clip_q;
  logic [PosW-1:0]    index_q;
  logic [CmdBits-1:0] cmd_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign step        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_min    <= RstLeaderMin;
      cfg_q.leader_max    <= RstLeaderMax;
      cfg_q.one_min       <= RstOneMin;
      cfg_q.one_max       <= RstOneMax;
      cfg_q.frame_timeout <= RstFrameTimeout;
      cfg_q.sample_period <= RstSamplePeriod;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgLeaderMin:    cfg_q.leader_min    <= cfg_data_i;
        CfgLeaderMax:    cfg_q.leader_max    <= cfg_data_i;
        CfgOneMin:       cfg_q.one_min       <= cfg_data_i;
        CfgOneMax:       cfg_q.one_max       <= cfg_data_i;
        CfgFrameTimeout: cfg_q.frame_timeout <= cfg_data_i;
        CfgSamplePeriod: cfg_q.sample_period <= cfg_data_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  ircp_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .edge_i (edge_req_i),
    .cfg_i  (cfg_q),
    .evt_o  (evt)
  );

  ircp_player u_player (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .evt_i    (evt),
    .period_i (cfg_q.sample_period),
    .smp_o    (smp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      svalid_q <= smp.valid;
      clip_q   <= smp.clip;
      index_q  <= smp.index;
      done_q   <= evt.done;
      ok_q     <= evt.ok;
      cmd_q    <= evt.cmd;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_valid_o = svalid_q;
  assign clip_o         = clip_q;
  assign sample_index_o = index_q;
  assign frame_done_o   = done_q;
  assign frame_ok_o     = ok_q;
  assign command_o      = cmd_q;

`ifndef SYNTHESIS
  a_no_sample_on_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(sample_valid_o && frame_done_o))
    else $error("sample due on a decode tick");

  a_bad_frame_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_ok_o) |-> (command_o == '0))
    else $error("command reported for a rejected frame");

  a_ok_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_ok_o) |-> frame_done_o)
    else $error("frame_ok without frame_done");

  a_idle_sample_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !sample_valid_o) |-> (clip_o == '0 && sample_index_o == '0))
    else $error("sample fields set with no sample due");

  a_index_in_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sample_valid_o) |-> (sample_index_o < clip_len(clip_o)))
    else $error("sample index beyond clip length");
`endif

endmodule
